// ===== design/rdc_pkg.sv =====
// Package: sizes, payload types, controller/datapath command and status structs.
package rdc_pkg;
    localparam int ENTRIES    = 1024;
    localparam int BLOCK      = 32;
    localparam int PLACES     = 10;
    localparam int RADIX      = 10;
    localparam int NBLOCKS    = (ENTRIES + BLOCK - 1) / BLOCK;
    localparam int HIST_DEPTH = NBLOCKS * PLACES * RADIX;
    localparam int POS_W      = 10;
    localparam int VAL_W      = 31;
    localparam int CNT_W      = 11;
    localparam int DIG_W      = 4;
    localparam int BCD_W      = PLACES * DIG_W;
    localparam int PT_W       = POS_W + 1;
    localparam int OFF_W      = $clog2(BLOCK);
    localparam int BLK_W      = POS_W - OFF_W;
    localparam int HC_W       = $clog2(BLOCK + 1);
    localparam int HA_W       = $clog2(HIST_DEPTH);
    localparam int CLR_LEN    = (HIST_DEPTH > ENTRIES) ? HIST_DEPTH : ENTRIES;
    localparam int CLR_W      = $clog2(CLR_LEN);
    localparam int CONV_W     = $clog2(VAL_W);
    localparam int K_W        = $clog2(PLACES);

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef struct packed {
        logic             func;
        logic [POS_W-1:0] position;
        logic [VAL_W-1:0] value;
        logic [POS_W-1:0] lo;
        logic [POS_W-1:0] hi;
        logic [DIG_W-1:0] digit;
        logic [DIG_W-1:0] wanted;
    } t_in_item;

    typedef struct packed {
        logic [CNT_W-1:0] count;
    } t_out_item;

    typedef struct packed {
        logic           clr_en;
        logic           wr_start;
        logic           conv_en;
        logic           h_rd;
        logic           h_wr;
        logic           h_inc;
        logic [K_W-1:0] place;
        logic           v_wr;
        logic           q_start;
        logic           q_issue;
        logic           out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic conv_last;
        logic q_ok;
        logic q_last;
    } t_dp_sts;

    // histogram entry address: block, place, digit value
    function automatic logic [HA_W-1:0] hist_addr(input logic [BLK_W-1:0] blk,
                                                  input logic [K_W-1:0] place,
                                                  input logic [DIG_W-1:0] d);
        int a;
        a = int'(blk) * PLACES * RADIX + int'(place) * RADIX + int'(d);
        return a[HA_W-1:0];
    endfunction
endpackage

// ===== design/rdc_if.sv =====
// Valid/ready channel interfaces for input and result items.
interface rdc_in_if;
    logic              valid;
    logic              ready;
    rdc_pkg::t_in_item payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface rdc_out_if;
    logic               valid;
    logic               ready;
    rdc_pkg::t_out_item payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/range_digit_count_table_top.sv =====
// Top level: range digit count table, controller plus datapath.
// Write item: accept, shift-and-add-3 BCD conversion, histogram update (per place: old digit read
// and decremented, new digit read and incremented), value store write, result load. Query item:
// range check, one scan read per partial-block value or whole block, drain, result load. One item
// at a time; the scan is bound by the single read port of each memory. Reset: synchronous active
// low; then a clearing pass over the memories (histogram size) runs while input ready stays low.
module range_digit_count_table_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rdc_in_if.sink     i_in,
    rdc_out_if.source  o_out
);
    rdc_pkg::t_dp_cmd            cmd;
    rdc_pkg::t_dp_sts            sts;
    logic [rdc_pkg::CNT_W-1:0]   count;

    // controller: sequencing and handshakes
    rdc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_func   (i_in.payload.func),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // datapath: memories, converter, scan, result register
    // (reset only restarts the clearing sweep counters)
    rdc_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_item  (i_in.payload),
        .o_sts   (sts),
        .o_count (count)
    );

    assign o_out.payload.count = count;
endmodule

// ===== design/rdc_datapath.sv =====
// Datapath: BCD value store, histogram memory, converter, query scan and result register.
module rdc_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  rdc_pkg::t_dp_cmd             i_cmd,
    input  rdc_pkg::t_in_item            i_item,
    output rdc_pkg::t_dp_sts             o_sts,
    output logic [rdc_pkg::CNT_W-1:0]    o_count
);
    logic [rdc_pkg::BCD_W-1:0] r_vmem [rdc_pkg::ENTRIES];
    logic [rdc_pkg::HC_W-1:0]  r_hmem [rdc_pkg::HIST_DEPTH];

    logic [rdc_pkg::CLR_W-1:0]  r_clr_addr;
    logic [rdc_pkg::DIG_W-1:0]  r_clr_d;
    logic [rdc_pkg::VAL_W-1:0]  r_bin;
    logic [rdc_pkg::BCD_W-1:0]  r_bcd;
    logic [rdc_pkg::CONV_W-1:0] r_conv_cnt;
    logic [rdc_pkg::POS_W-1:0]  r_wpos;
    logic [rdc_pkg::BCD_W-1:0]  r_vrd;
    logic [rdc_pkg::HC_W-1:0]   r_hrd;
    logic [rdc_pkg::HA_W-1:0]   r_haddr;
    logic [rdc_pkg::PT_W-1:0]   r_ptr;
    logic [rdc_pkg::PT_W-1:0]   r_hi;
    logic [rdc_pkg::K_W-1:0]    r_qplace;
    logic [rdc_pkg::DIG_W-1:0]  r_want;
    logic                       r_qok;
    logic                       r_pend;
    logic                       r_kind;
    logic [rdc_pkg::CNT_W-1:0]  r_acc;
    logic [rdc_pkg::CNT_W-1:0]  r_count;

    logic [rdc_pkg::BCD_W-1:0]  adj;
    logic [rdc_pkg::PT_W-1:0]   hi_sat;
    logic [rdc_pkg::PT_W-1:0]   lo_ext;
    logic                       qok;
    logic                       whole;
    logic [rdc_pkg::PT_W-1:0]   n_ptr;
    logic [rdc_pkg::DIG_W-1:0]  h_dig;
    logic [rdc_pkg::HA_W-1:0]   h_raddr;
    logic [rdc_pkg::DIG_W-1:0]  scan_dig;

    // add-3 correction per BCD digit
    always_comb begin
        for (int i = 0; i < rdc_pkg::PLACES; i++) begin
            if (r_bcd[i*rdc_pkg::DIG_W +: rdc_pkg::DIG_W] >= rdc_pkg::DIG_W'(5)) begin
                adj[i*rdc_pkg::DIG_W +: rdc_pkg::DIG_W] =
                    r_bcd[i*rdc_pkg::DIG_W +: rdc_pkg::DIG_W] + rdc_pkg::DIG_W'(3);
            end else begin
                adj[i*rdc_pkg::DIG_W +: rdc_pkg::DIG_W] =
                    r_bcd[i*rdc_pkg::DIG_W +: rdc_pkg::DIG_W];
            end
        end
    end

    always_comb begin
        lo_ext = {1'b0, i_item.lo};
        hi_sat = ({1'b0, i_item.hi} >= rdc_pkg::PT_W'(rdc_pkg::ENTRIES))
                 ? rdc_pkg::PT_W'(rdc_pkg::ENTRIES - 1) : {1'b0, i_item.hi};
        qok = (i_item.digit >= rdc_pkg::DIG_W'(1))
              && (i_item.digit <= rdc_pkg::DIG_W'(rdc_pkg::PLACES))
              && (i_item.wanted <= rdc_pkg::DIG_W'(rdc_pkg::RADIX - 1))
              && (lo_ext < rdc_pkg::PT_W'(rdc_pkg::ENTRIES))
              && (lo_ext <= hi_sat);
        whole = (r_ptr[rdc_pkg::OFF_W-1:0] == '0)
                && (r_ptr + rdc_pkg::PT_W'(rdc_pkg::BLOCK - 1) <= r_hi);
        n_ptr = whole ? r_ptr + rdc_pkg::PT_W'(rdc_pkg::BLOCK) : r_ptr + rdc_pkg::PT_W'(1);
        h_dig = i_cmd.h_inc ? r_bcd[i_cmd.place*rdc_pkg::DIG_W +: rdc_pkg::DIG_W]
                            : r_vrd[i_cmd.place*rdc_pkg::DIG_W +: rdc_pkg::DIG_W];
        if (i_cmd.q_issue) begin
            h_raddr = rdc_pkg::hist_addr(r_ptr[rdc_pkg::POS_W-1:rdc_pkg::OFF_W],
                                         r_qplace, r_want);
        end else begin
            h_raddr = rdc_pkg::hist_addr(r_wpos[rdc_pkg::POS_W-1:rdc_pkg::OFF_W],
                                         i_cmd.place, h_dig);
        end
        scan_dig = r_vrd[r_qplace*rdc_pkg::DIG_W +: rdc_pkg::DIG_W];
    end

    // value store
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_en && (r_clr_addr < rdc_pkg::CLR_W'(rdc_pkg::ENTRIES))) begin
            r_vmem[r_clr_addr[rdc_pkg::POS_W-1:0]] <= '0;
        end else if (i_cmd.v_wr) begin
            r_vmem[r_wpos] <= r_bcd;
        end
        if (i_cmd.wr_start) begin
            r_vrd <= r_vmem[i_item.position];
        end else if (i_cmd.q_issue && !whole) begin
            r_vrd <= r_vmem[r_ptr[rdc_pkg::POS_W-1:0]];
        end
    end

    // histogram memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_en && (r_clr_addr < rdc_pkg::CLR_W'(rdc_pkg::HIST_DEPTH))) begin
            r_hmem[r_clr_addr[rdc_pkg::HA_W-1:0]] <= (r_clr_d == '0)
                ? rdc_pkg::HC_W'(rdc_pkg::BLOCK) : '0;
        end else if (i_cmd.h_wr) begin
            r_hmem[r_haddr] <= i_cmd.h_inc ? r_hrd + rdc_pkg::HC_W'(1)
                                           : r_hrd - rdc_pkg::HC_W'(1);
        end
        if (i_cmd.h_rd || (i_cmd.q_issue && whole)) begin
            r_hrd   <= r_hmem[h_raddr];
            r_haddr <= h_raddr;
        end
    end

    always_ff @(posedge i_clk) begin
        // clear sweep counters (r_clr_d tracks the digit-value slot)
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_clr_d    <= '0;
        end else if (i_cmd.clr_en) begin
            r_clr_addr <= r_clr_addr + rdc_pkg::CLR_W'(1);
            r_clr_d    <= (r_clr_d == rdc_pkg::DIG_W'(rdc_pkg::RADIX - 1))
                          ? '0 : r_clr_d + rdc_pkg::DIG_W'(1);
        end else if (i_cmd.out_load) begin
            r_clr_addr <= '0;
            r_clr_d    <= '0;
        end
        if (i_cmd.wr_start) begin
            r_bin      <= i_item.value;
            r_bcd      <= '0;
            r_conv_cnt <= '0;
            r_wpos     <= i_item.position;
        end else if (i_cmd.conv_en) begin
            r_bcd      <= {adj[rdc_pkg::BCD_W-2:0], r_bin[rdc_pkg::VAL_W-1]};
            r_bin      <= {r_bin[rdc_pkg::VAL_W-2:0], 1'b0};
            r_conv_cnt <= r_conv_cnt + rdc_pkg::CONV_W'(1);
        end
        if (i_cmd.q_start) begin
            r_ptr    <= lo_ext;
            r_hi     <= hi_sat;
            r_qplace <= rdc_pkg::K_W'(i_item.digit - rdc_pkg::DIG_W'(1));
            r_want   <= i_item.wanted;
            r_qok    <= qok;
        end else if (i_cmd.q_issue) begin
            r_ptr <= n_ptr;
        end
        r_pend <= i_cmd.q_issue;
        r_kind <= whole;
        if (i_cmd.q_start || i_cmd.wr_start) begin
            r_acc <= '0;
        end else if (r_pend) begin
            if (r_kind) begin
                r_acc <= r_acc + rdc_pkg::CNT_W'(r_hrd);
            end else if (scan_dig == r_want) begin
                r_acc <= r_acc + rdc_pkg::CNT_W'(1);
            end
        end
        if (i_cmd.out_load) begin
            r_count <= r_acc;
        end
    end

    assign o_sts.clr_last  = (r_clr_addr == rdc_pkg::CLR_W'(rdc_pkg::CLR_LEN - 1));
    assign o_sts.conv_last = (r_conv_cnt == rdc_pkg::CONV_W'(rdc_pkg::VAL_W - 1));
    assign o_sts.q_ok      = r_qok;
    assign o_sts.q_last    = (n_ptr > r_hi);
    assign o_count         = r_count;
endmodule

// ===== design/rdc_ctrl.sv =====
// Controller: clear sweep, write update sequence, query scan and output handshake.
module rdc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_func,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  rdc_pkg::t_dp_sts i_sts,
    output rdc_pkg::t_dp_cmd o_cmd
);
    typedef enum logic [9:0] {
        ST_CLEAR  = 10'b0000000001,
        ST_IDLE   = 10'b0000000010,
        ST_CONV   = 10'b0000000100,
        ST_HRD    = 10'b0000001000,
        ST_HWR    = 10'b0000010000,
        ST_VWR    = 10'b0000100000,
        ST_QCHK   = 10'b0001000000,
        ST_QRY    = 10'b0010000000,
        ST_QDRAIN = 10'b0100000000,
        ST_FIN    = 10'b1000000000
    } t_state;

    t_state                 r_state, n_state;
    logic [rdc_pkg::K_W-1:0] r_k, n_k;
    logic                   r_inc, n_inc;
    logic                   r_ov, n_ov;
    logic                   accept;

    assign o_in_ready  = (r_state == ST_IDLE) && (!r_ov || i_out_ready);
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_ov;

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_inc   = r_inc;
        n_ov    = (r_ov && i_out_ready) ? 1'b0 : r_ov;
        o_cmd   = '0;
        o_cmd.place = r_k;
        o_cmd.h_inc = r_inc;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_en = 1'b1;
                if (i_sts.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (accept) begin
                    if (i_in_func == rdc_pkg::FUNC_WRITE) begin
                        o_cmd.wr_start = 1'b1;
                        n_state = ST_CONV;
                    end else begin
                        o_cmd.q_start = 1'b1;
                        n_state = ST_QCHK;
                    end
                end
            end
            ST_CONV: begin
                o_cmd.conv_en = 1'b1;
                if (i_sts.conv_last) begin
                    n_state = ST_HRD;
                    n_k     = '0;
                    n_inc   = 1'b0;
                end
            end
            ST_HRD: begin
                o_cmd.h_rd = 1'b1;
                n_state = ST_HWR;
            end
            ST_HWR: begin
                o_cmd.h_wr = 1'b1;
                if (!r_inc) begin
                    n_inc   = 1'b1;
                    n_state = ST_HRD;
                end else begin
                    n_inc = 1'b0;
                    if (r_k == rdc_pkg::K_W'(rdc_pkg::PLACES - 1)) begin
                        n_state = ST_VWR;
                    end else begin
                        n_k     = r_k + rdc_pkg::K_W'(1);
                        n_state = ST_HRD;
                    end
                end
            end
            ST_VWR: begin
                o_cmd.v_wr = 1'b1;
                n_state = ST_FIN;
            end
            ST_QCHK: begin
                n_state = i_sts.q_ok ? ST_QRY : ST_FIN;
            end
            ST_QRY: begin
                o_cmd.q_issue = 1'b1;
                if (i_sts.q_last) n_state = ST_QDRAIN;
            end
            ST_QDRAIN: begin
                n_state = ST_FIN;
            end
            ST_FIN: begin
                o_cmd.out_load = 1'b1;
                n_ov    = 1'b1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_k     <= '0;
            r_inc   <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_inc   <= n_inc;
            r_ov    <= n_ov;
        end
    end
endmodule

// ===== design/rdc_checker.sv =====
// Port-level checker for the top level, attached by bind.
module rdc_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      i_in_ready,
    input logic                      i_in_func,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic [rdc_pkg::CNT_W-1:0] i_count
);
    logic r_last_func;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_func <= rdc_pkg::FUNC_QUERY;
        end else if (i_in_valid && i_in_ready) begin
            r_last_func <= i_in_func;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_count))
        else $error("result item changed while stalled");

    a_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (r_last_func == rdc_pkg::FUNC_WRITE) |-> i_count == '0)
        else $error("write item gave nonzero count");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_count <= rdc_pkg::CNT_W'(rdc_pkg::ENTRIES))
        else $error("count above table size");

    a_one_at_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input accepted while busy");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |-> !(i_out_valid && !i_out_ready))
        else $error("input accepted while result stalled");
endmodule

bind range_digit_count_table_top rdc_checker u_rdc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_func   (i_in.payload.func),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_count     (o_out.payload.count)
);
